// ===== design/lsq_pkg.sv =====
// shared widths, constants and defaults for the largest square of ones block
package lsq_pkg;

  // side length and register widths
  localparam int SIDE_W = 11;
  localparam int CFG_W  = 11;

  typedef logic [SIDE_W-1:0] side_t;
  typedef logic [CFG_W-1:0]  cfg_t;

  // top value a side saturates at
  localparam side_t SIDE_TOP = {SIDE_W{1'b1}};

  // default line store depth and row length after reset
  localparam int   MAX_COLUMNS_DEFAULT = 1024;
  localparam cfg_t COLUMN_COUNT_RESET  = cfg_t'(1024);

endpackage

// ===== design/largest_square_of_ones.sv =====
// largest square of ones: maximal square search over a raster stream of cells
//
// Cells arrive one per transaction in raster order, column_count cells per row
// (0 is taken as 1, values above MAX_COLUMNS as MAX_COLUMNS). A transaction
// marked last_cell returns the side of the largest all-ones square of the
// matrix and restarts the search. One cell is taken every cycle unless input
// stalls: the cell enters, reads the previous row's side from the line store
// into the compute stage, where its side is computed and written back to the
// same entry, with the in-flight write forwarded to a read of the same
// column. Results sit in an output register, so input keeps flowing while a
// result waits; input stalls only while a last cell waits behind an untaken
// result. No clearing pass after reset is needed.
module largest_square_of_ones #(
  parameter int MAX_COLUMNS = lsq_pkg::MAX_COLUMNS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  lsq_pkg::cfg_t       column_count,
  // cell input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                cell_value,
  input  logic                last_cell,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output lsq_pkg::side_t      largest_size
);
  import lsq_pkg::*;

  localparam int AW     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int NW_RAW = $clog2(MAX_COLUMNS + 1);
  localparam int CW     = (NW_RAW > CFG_W) ? NW_RAW : CFG_W;

  typedef logic [CW-1:0] cnt_t;

  // row length register
  cfg_t row_cfg;

  // entry stage state
  cnt_t column_position;
  logic in_first_row;

  // compute stage registers
  logic            s1_valid;
  logic [AW-1:0]   s1_pos;
  logic            s1_first;
  logic            s1_cell;
  logic            s1_last;
  logic            s1_wrap;
  side_t           rd_data;
  logic            fwd_hit;
  side_t           fwd_data;

  // running side state
  side_t left_size;
  side_t diagonal_size;
  side_t best_size;

  // line store
  side_t line_mem [MAX_COLUMNS];

  logic  in_fire, s1_fire;
  cnt_t  cfg_ext, row_len, pos_eff, pos_inc;
  logic  first_eff, row_end;
  side_t up_mem, up, min_lu, min_all, side, best_next;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cfg <= COLUMN_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      row_cfg <= column_count;
    end
  end

  // clamped row length
  always_comb begin
    cfg_ext = cnt_t'(row_cfg);
    if (row_cfg == '0) begin
      row_len = cnt_t'(1);
    end else if (cfg_ext > cnt_t'(MAX_COLUMNS)) begin
      row_len = cnt_t'(MAX_COLUMNS);
    end else begin
      row_len = cfg_ext;
    end
  end

  // handshake
  assign s1_fire  = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;

  // entry stage: column tracking
  always_comb begin
    if (column_position >= row_len) begin
      pos_eff   = '0;
      first_eff = 1'b0;
    end else begin
      pos_eff   = column_position;
      first_eff = in_first_row;
    end
    pos_inc = pos_eff + cnt_t'(1);
    row_end = (pos_inc >= row_len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      in_first_row    <= 1'b1;
    end else if (in_fire) begin
      if (last_cell) begin
        column_position <= '0;
        in_first_row    <= 1'b1;
      end else if (row_end) begin
        column_position <= '0;
        in_first_row    <= 1'b0;
      end else begin
        column_position <= pos_inc;
        in_first_row    <= first_eff;
      end
    end
  end

  // line store write and read, with forwarding of the same-cycle write
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      line_mem[s1_pos] <= side;
    end
    if (in_fire) begin
      rd_data  <= line_mem[pos_eff[AW-1:0]];
      fwd_hit  <= s1_fire && (s1_pos == pos_eff[AW-1:0]);
      fwd_data <= side;
    end
  end

  // compute stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pos   <= pos_eff[AW-1:0];
      s1_first <= first_eff;
      s1_cell  <= cell_value;
      s1_last  <= last_cell;
      s1_wrap  <= row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  // side of the square ending at this cell
  always_comb begin
    up_mem  = fwd_hit ? fwd_data : rd_data;
    up      = s1_first ? '0 : up_mem;
    min_lu  = (left_size < up) ? left_size : up;
    min_all = (diagonal_size < min_lu) ? diagonal_size : min_lu;
    if (!s1_cell) begin
      side = '0;
    end else if (s1_first || (s1_pos == '0)) begin
      side = side_t'(1);
    end else if (min_all == SIDE_TOP) begin
      side = SIDE_TOP;
    end else begin
      side = min_all + side_t'(1);
    end
    best_next = (side > best_size) ? side : best_size;
  end

  // running left, diagonal and best sides
  always_ff @(posedge clk) begin
    if (rst) begin
      left_size     <= '0;
      diagonal_size <= '0;
      best_size     <= '0;
    end else if (s1_fire) begin
      if (s1_last) begin
        left_size     <= '0;
        diagonal_size <= '0;
        best_size     <= '0;
      end else begin
        left_size     <= s1_wrap ? '0 : side;
        diagonal_size <= s1_wrap ? '0 : up;
        best_size     <= best_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      largest_size <= best_next;
    end
  end

endmodule

// ===== design/lsq_checker.sv =====
// port-level checker for the largest square of ones block, with its bind
module lsq_checker #(
  parameter int MAX_COLUMNS = lsq_pkg::MAX_COLUMNS_DEFAULT
) (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           last_cell,
  input logic           out_valid,
  input logic           out_ready,
  input lsq_pkg::side_t largest_size
);
  import lsq_pkg::*;

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // a pending result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(largest_size))
    else $error("result changed while stalled");

  // a fresh result follows an accepted last cell
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && last_cell, 2))
    else $error("result without a preceding last cell");

  // a square side never exceeds the row capacity
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(largest_size) <= 32'(MAX_COLUMNS)))
    else $error("result side out of range");

endmodule

bind largest_square_of_ones lsq_checker #(
  .MAX_COLUMNS(MAX_COLUMNS)
) u_lsq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .last_cell   (last_cell),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .largest_size(largest_size)
);
